// ===== hw/rtl/vc69_pkg.sv =====
`timescale 1ns / 1ps
// vc69_pkg: shared types, register indexes and symbol mapping for the
// 69-symbol Vigenere cipher. No dependencies.
package vc69_pkg;

    localparam int MAX_KEY_CHARS = 32;
    localparam int KEY_WORDS     = 4;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 64;

    typedef logic [6:0] t_sym;
    typedef logic [4:0] t_key_pos;
    typedef logic [5:0] t_key_len;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIRECTION    = 3'd0,
        CFG_KEY_LENGTH   = 3'd1,
        CFG_KEY_LO       = 3'd2,
        CFG_KEY_MID_LO   = 3'd3,
        CFG_KEY_MID_HI   = 3'd4,
        CFG_KEY_HI       = 3'd5
    } t_cfg_idx;

    localparam t_sym SYM_MOD   = 7'd69;
    localparam t_sym SYM_OTHER = 7'd68;

    // byte to alphabet index
    function automatic t_sym sym_index(input logic [7:0] b);
        t_sym r;
        r = SYM_OTHER;
        if (b >= 8'd48 && b <= 8'd57) begin
            r = t_sym'(b - 8'd48);
        end else if (b >= 8'd97 && b <= 8'd122) begin
            r = t_sym'(b - 8'd87);
        end else if (b >= 8'd65 && b <= 8'd90) begin
            r = t_sym'(b - 8'd29);
        end else begin
            case (b)
                8'd44:   r = 7'd62;
                8'd46:   r = 7'd63;
                8'd59:   r = 7'd64;
                8'd63:   r = 7'd65;
                8'd33:   r = 7'd66;
                8'd40:   r = 7'd67;
                default: r = SYM_OTHER;
            endcase
        end
        return r;
    endfunction

    // alphabet index to byte
    function automatic logic [7:0] sym_byte(input t_sym s);
        logic [7:0] r;
        r = 8'd41;
        if (s <= 7'd9) begin
            r = {1'b0, s} + 8'd48;
        end else if (s <= 7'd35) begin
            r = {1'b0, s} + 8'd87;
        end else if (s <= 7'd61) begin
            r = {1'b0, s} + 8'd29;
        end else begin
            case (s)
                7'd62:   r = 8'd44;
                7'd63:   r = 8'd46;
                7'd64:   r = 8'd59;
                7'd65:   r = 8'd63;
                7'd66:   r = 8'd33;
                7'd67:   r = 8'd40;
                default: r = 8'd41;
            endcase
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/vigenere_cipher_69_symbol.sv =====
`timescale 1ns / 1ps
// Top level of the 69-symbol Vigenere cipher: key store, key position,
// two-stage datapath. Depends on vc69_pkg.
// Each item is registered in stage 1 as symbols, then in the output register as a byte.
// Throughput: one item per cycle while i_stall is low; stage 1 can still fill while the output is held.
// Reset (synchronous, active low): empties both stages, key position 0,
// encrypt, key length 1, key bytes 0.
module vigenere_cipher_69_symbol (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [7:0]                       i_text_char,
    input  logic                             i_restart,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_out_char,
    input  logic                             i_cfg_we,
    input  logic [vc69_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vc69_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                              r_direction;
    vc69_pkg::t_key_len                r_key_length;
    logic [vc69_pkg::CFG_DATA_W-1:0]   r_key_words [vc69_pkg::KEY_WORDS];
    vc69_pkg::t_key_pos                r_key_pos;

    logic                r_s1_valid;
    vc69_pkg::t_sym      r_s1_m;
    vc69_pkg::t_sym      r_s1_k;
    logic                r_out_valid;
    logic [7:0]          r_out_char;

    logic                w_out_load;
    logic                w_s1_load;
    logic                w_accept;
    vc69_pkg::t_key_len  w_len;
    vc69_pkg::t_key_pos  w_pos;
    logic [7:0]          w_key_byte;
    vc69_pkg::t_key_pos  n_key_pos;
    logic [5:0]          w_pos_inc;
    logic [7:0]          w_sum;
    logic [7:0]          w_mod;
    logic [7:0]          n_out_char;

    assign w_out_load = !r_out_valid || !i_stall;
    assign w_s1_load  = !r_s1_valid || w_out_load;
    assign o_stall    = !w_s1_load;
    assign w_accept   = i_valid && w_s1_load;
    assign o_valid    = r_out_valid;
    assign o_out_char = r_out_char;

    // key position for this item
    always_comb begin
        if (r_key_length == 6'd0) begin
            w_len = 6'd1;
        end else if (r_key_length > 6'(vc69_pkg::MAX_KEY_CHARS)) begin
            w_len = 6'(vc69_pkg::MAX_KEY_CHARS);
        end else begin
            w_len = r_key_length;
        end
        w_pos = i_restart ? 5'd0 : r_key_pos;
        if ({1'b0, w_pos} >= w_len) begin
            w_pos = 5'd0;
        end
        w_key_byte = r_key_words[w_pos[4:3]][{w_pos[2:0], 3'b000} +: 8];
        w_pos_inc  = {1'b0, w_pos} + 6'd1;
        n_key_pos  = (w_pos_inc >= w_len) ? 5'd0 : w_pos_inc[4:0];
    end

    // modular add or subtract
    always_comb begin
        if (r_direction) begin
            w_sum = {1'b0, r_s1_m} + {1'b0, vc69_pkg::SYM_MOD} - {1'b0, r_s1_k};
        end else begin
            w_sum = {1'b0, r_s1_m} + {1'b0, r_s1_k};
        end
        w_mod      = (w_sum >= {1'b0, vc69_pkg::SYM_MOD})
                   ? w_sum - {1'b0, vc69_pkg::SYM_MOD} : w_sum;
        n_out_char = vc69_pkg::sym_byte(w_mod[6:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction  <= 1'b0;
            r_key_length <= 6'd1;
            for (int i = 0; i < vc69_pkg::KEY_WORDS; i++) begin
                r_key_words[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vc69_pkg::CFG_DIRECTION:  r_direction    <= i_cfg_data[0];
                vc69_pkg::CFG_KEY_LENGTH: r_key_length   <= i_cfg_data[5:0];
                vc69_pkg::CFG_KEY_LO:     r_key_words[0] <= i_cfg_data;
                vc69_pkg::CFG_KEY_MID_LO: r_key_words[1] <= i_cfg_data;
                vc69_pkg::CFG_KEY_MID_HI: r_key_words[2] <= i_cfg_data;
                vc69_pkg::CFG_KEY_HI:     r_key_words[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_pos   <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_key_pos <= n_key_pos;
            end
            if (w_s1_load) begin
                r_s1_valid <= i_valid;
            end
            if (w_out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_m <= vc69_pkg::sym_index(i_text_char);
            r_s1_k <= vc69_pkg::sym_index(w_key_byte);
        end
        if (w_out_load && r_s1_valid) begin
            r_out_char <= n_out_char;
        end
    end

endmodule

// ===== hw/rtl/vc69_checker.sv =====
`timescale 1ns / 1ps
// vc69_checker: port-level assertions for vigenere_cipher_69_symbol,
// bound to the top level below. No other dependencies.
module vc69_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             o_stall,
    input logic                             o_valid,
    input logic                             i_stall,
    input logic [7:0]                       o_out_char
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_char))
        else $error("stalled item changed");

    // back-pressure only when a result is blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("stall without blocked output");

    // results are always alphabet bytes
    a_alphabet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_char >= 8'd48 && o_out_char <= 8'd57)
                 || (o_out_char >= 8'd97 && o_out_char <= 8'd122)
                 || (o_out_char >= 8'd65 && o_out_char <= 8'd90)
                 || o_out_char == 8'd44 || o_out_char == 8'd46
                 || o_out_char == 8'd59 || o_out_char == 8'd63
                 || o_out_char == 8'd33 || o_out_char == 8'd40
                 || o_out_char == 8'd41)
        else $error("result outside alphabet");

endmodule

bind vigenere_cipher_69_symbol vc69_checker u_vc69_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_out_char  (o_out_char)
);

// ===== bench/vigenere_cipher_69_symbol_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for vigenere_cipher_69_symbol: directed and random items
// checked against an in-bench cipher predictor. Depends on vc69_pkg and the RTL.
module vigenere_cipher_69_symbol_tb;

    localparam int HALF_PERIOD = 2;
    localparam int LATENCY     = 2;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 2000;
    localparam int N_SYMS      = 69;
    localparam logic [8*N_SYMS-1:0] ALPHABET =
        "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ,.;?!()";

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_valid     = 1'b0;
    logic [7:0]            i_text_char = 8'd0;
    logic                  i_restart   = 1'b0;
    logic                  i_stall     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [vc69_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [vc69_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  o_stall;
    logic                  o_valid;
    logic [7:0]            o_out_char;

    // predictor state
    logic       key_dir = 1'b0;
    logic [5:0] key_len = 6'd1;
    logic [4:0] key_pos = 5'd0;
    logic [7:0] key_bytes [vc69_pkg::MAX_KEY_CHARS];

    logic [7:0] expected_chars [$];
    logic [7:0] want_char;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int hold_left      = 0;
    int idle_cycles    = 0;
    int chars_sent     = 0;
    int chars_checked  = 0;
    int stalled_offers = 0;
    int mismatches     = 0;

    vigenere_cipher_69_symbol dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_text_char (i_text_char),
        .i_restart   (i_restart),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [7:0] alpha_char(input int unsigned s);
        return ALPHABET[8*(N_SYMS-1-s) +: 8];
    endfunction

    // bytes outside the alphabet, ')' included, land on the last symbol
    function automatic int unsigned alpha_pos(input logic [7:0] b);
        int unsigned s;
        s = N_SYMS - 1;
        for (int i = N_SYMS - 2; i >= 0; i--) begin
            if (alpha_char(i) == b) s = i;
        end
        return s;
    endfunction

    function automatic logic [7:0] cipher_next(input logic [7:0] text, input logic restart);
        int unsigned len, pos, k, m, r;
        len = key_len;
        if (len == 0) len = 1;
        if (len > vc69_pkg::MAX_KEY_CHARS) len = vc69_pkg::MAX_KEY_CHARS;
        pos = restart ? 0 : key_pos;
        if (pos >= len) pos = 0;
        k = alpha_pos(key_bytes[pos]);
        m = alpha_pos(text);
        r = key_dir ? (m + N_SYMS - k) % N_SYMS : (m + k) % N_SYMS;
        key_pos = (pos + 1 >= len) ? 5'd0 : 5'(pos + 1);
        return alpha_char(r);
    endfunction

    function automatic logic [7:0] rand_text();
        if ($urandom_range(3) != 0) return alpha_char($urandom_range(N_SYMS - 1));
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [63:0] rand_key_word();
        logic [63:0] w;
        for (int b = 0; b < 8; b++) begin
            if ($urandom_range(4) == 0) w[8*b +: 8] = 8'($urandom_range(255));
            else w[8*b +: 8] = alpha_char($urandom_range(N_SYMS - 1));
        end
        return w;
    endfunction

    function automatic logic [5:0] rand_key_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 5) return 6'd0;
        if (p < 10) return 6'($urandom_range(63, 33));
        if (p < 20) return 6'd32;
        if (p < 30) return 6'd1;
        return 6'($urandom_range(31, 2));
    endfunction

    // leaves the write enable high; load_key lowers it after the last write
    task automatic write_reg(input vc69_pkg::t_cfg_idx idx, input logic [63:0] data);
        int w;
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        w = -1;
        case (idx)
            vc69_pkg::CFG_DIRECTION:  key_dir = data[0];
            vc69_pkg::CFG_KEY_LENGTH: key_len = data[5:0];
            vc69_pkg::CFG_KEY_LO:     w = 0;
            vc69_pkg::CFG_KEY_MID_LO: w = 1;
            vc69_pkg::CFG_KEY_MID_HI: w = 2;
            vc69_pkg::CFG_KEY_HI:     w = 3;
            default: ;
        endcase
        if (w >= 0) begin
            for (int b = 0; b < 8; b++) key_bytes[8*w + b] = data[8*b +: 8];
        end
    endtask

    task automatic load_key(input logic dir, input logic [5:0] len,
                            input logic [63:0] w0, input logic [63:0] w1,
                            input logic [63:0] w2, input logic [63:0] w3);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(vc69_pkg::CFG_DIRECTION, {junk[63:1], dir});
        junk = {$urandom, $urandom};
        write_reg(vc69_pkg::CFG_KEY_LENGTH, {junk[63:6], len});
        write_reg(vc69_pkg::CFG_KEY_LO, w0);
        write_reg(vc69_pkg::CFG_KEY_MID_LO, w1);
        write_reg(vc69_pkg::CFG_KEY_MID_HI, w2);
        write_reg(vc69_pkg::CFG_KEY_HI, w3);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_char(input logic [7:0] text, input logic restart);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_text_char <= text;
        i_restart   <= restart;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        expected_chars.push_back(cipher_next(text, restart));
        chars_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    // key byte 0 after reset is outside the alphabet
    task automatic test_reset_state();
        send_char("0", 1'b0);
        send_char(8'hff, 1'b0);
    endtask

    task automatic test_symbol_extremes();
        logic [63:0] w0;
        w0 = {32'h0, 8'hff, "(", "9", "z"};
        settle();
        load_key(1'b0, 6'd4, w0, 64'h0, 64'h0, 64'h0);
        send_char(8'h00, 1'b1);
        send_char(8'hff, 1'b0);
        send_char("0", 1'b0);
        send_char("9", 1'b0);
        send_char("a", 1'b0);
        send_char("z", 1'b0);
        send_char("A", 1'b0);
        settle();
        load_key(1'b1, 6'd4, w0, 64'h0, 64'h0, 64'h0);
        send_char("Z", 1'b1);
        send_char(",", 1'b0);
        send_char(".", 1'b0);
        send_char(";", 1'b0);
        send_char("?", 1'b0);
        send_char("!", 1'b0);
        send_char("(", 1'b0);
        send_char(")", 1'b0);
    endtask

    // zero length acts as one, oversize lengths clamp to the key store
    task automatic test_length_limits();
        settle();
        load_key(1'b0, 6'd0, rand_key_word(), rand_key_word(), rand_key_word(),
                 rand_key_word());
        send_char(rand_text(), 1'b1);
        send_char(rand_text(), 1'b0);
        settle();
        load_key(1'b1, 6'd63, rand_key_word(), rand_key_word(), rand_key_word(),
                 rand_key_word());
        send_char(rand_text(), 1'b1);
        send_char(rand_text(), 1'b0);
    endtask

    // shorten the key while the position sits past the new length
    task automatic test_shrink_key();
        logic [63:0] w0;
        w0 = rand_key_word();
        settle();
        load_key(1'b0, 6'd8, w0, 64'h0, 64'h0, 64'h0);
        for (int j = 0; j < 5; j++) send_char(rand_text(), j == 0);
        settle();
        load_key(1'b0, 6'd3, w0, 64'h0, 64'h0, 64'h0);
        send_char(rand_text(), 1'b0);
        send_char(rand_text(), 1'b0);
    endtask

    task automatic test_receiver_hold();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        settle();
        load_key(1'b0, 6'd7, rand_key_word(), rand_key_word(), rand_key_word(),
                 rand_key_word());
        hold_left = HOLD_CYCLES;
        for (int j = 0; j < 40; j++) send_char(rand_text(), j == 0);
    endtask

    task automatic test_random_traffic(input int n_chars, input int s_pct, input int r_pct);
        int target;
        int seg;
        target = chars_sent + n_chars;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (chars_sent < target) begin
            settle();
            load_key(1'($urandom_range(1)), rand_key_len(), rand_key_word(),
                     rand_key_word(), rand_key_word(), rand_key_word());
            seg = $urandom_range(80, 15);
            for (int j = 0; j < seg; j++) begin
                send_char(rand_text(),
                          (j == 0) ? 1'($urandom_range(1)) : ($urandom_range(24) == 0));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            chars_checked++;
            if (expected_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: output 0x%02h with no item pending", $time, o_out_char);
            end else begin
                want_char = expected_chars.pop_front();
                if (o_out_char !== want_char) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: out_char expected 0x%02h got 0x%02h",
                                 $time, want_char, o_out_char);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_stall) stalled_offers++;
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < vc69_pkg::MAX_KEY_CHARS; i++) key_bytes[i] = 8'd0;
        send_idle_pct = 29;
        recv_idle_pct = 61;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_symbol_extremes();
        test_length_limits();
        test_shrink_key();
        test_random_traffic(310, 29, 61);
        test_receiver_hold();
        test_random_traffic(310, 61, 29);
        test_random_traffic(310, 0, 0);
        settle();
        $display("Sent %0d items, checked %0d outputs; %0d offers held back by the block.",
                 chars_sent, chars_checked, stalled_offers);
        $display("Both directions, key lengths 0 to 63, key shrink and a long output hold.");
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
